// ===== hdl/fader_deadband_pitch_bend_assert.svh =====
// Assertion macros shared by the checker of the fader deadband block.
`ifndef FADER_DEADBAND_PITCH_BEND_ASSERT_SVH
`define FADER_DEADBAND_PITCH_BEND_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDPB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fdpb_pkg.sv =====
// Package with the constants, types and helper functions of the fader deadband block.
`timescale 1ns / 1ps

package fdpb_pkg;

	localparam int NUM_FADERS          = 3;
	localparam int SAMPLES_PER_READING = 16;
	localparam int NUM_CHAN_REGS       = 3;
	localparam int QUEUE_DEPTH         = 2;

	localparam int FADER_W   = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1;
	localparam int FIDX_W    = 2;
	localparam int SAMPLE_W  = 10;
	localparam int POS_W     = 14;
	localparam int CNT_W     = $clog2(SAMPLES_PER_READING);
	localparam int THR_W     = 13;
	localparam int PER_W     = 10;
	localparam int CH_W      = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;
	localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [POS_W-1:0] BEND_CENTER   = POS_W'(8192);
	localparam logic [THR_W-1:0] THR_RESET     = THR_W'(32);
	localparam logic [PER_W-1:0] PERIOD_RESET  = PER_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_PERIOD    = 3'd1,
		CFG_CHAN0     = 3'd2,
		CFG_CHAN1     = 3'd3,
		CFG_CHAN2     = 3'd4
	} cfg_reg_t;

	typedef logic [NUM_CHAN_REGS-1:0][CH_W-1:0] chan_regs_t;

	// One pending message from the front end to the output stage.
	typedef struct packed {
		logic [FADER_W-1:0] fader;
		logic [POS_W-1:0]   pos;
		logic               is_refresh;
	} cmd_t;

	// Faders without a channel register use their number plus one.
	function automatic logic [CH_W-1:0] channel_of(input logic [FADER_W-1:0] f,
			input chan_regs_t regs);
		logic [CH_W-1:0] ch;
		ch = CH_W'(32'(f) + 32'd1);
		for (int i = 0; i < NUM_CHAN_REGS; i++) begin
			if (32'(f) == i)
				ch = regs[i];
		end
		return ch;
	endfunction

endpackage

// ===== hdl/fdpb_queue.sv =====
// Short command queue between the front end and the output stage.
`timescale 1ns / 1ps

module fdpb_queue
	import fdpb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic space,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign space      = (count_q < QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push & space;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/fdpb_front.sv =====
// Front end: takes transactions, keeps per-fader state and queues the messages to send.
`timescale 1ns / 1ps

module fdpb_front
	import fdpb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [FIDX_W-1:0]   fader_index,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic [THR_W-1:0]    threshold,
	input  logic [PER_W-1:0]    period,
	input  logic                q_space,
	output logic                push,
	output cmd_t                push_cmd
);

	logic                valid_s1;
	logic                func_s1;
	logic [FIDX_W-1:0]   fader_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic [POS_W-1:0]   sum_q    [NUM_FADERS];
	logic [CNT_W-1:0]   count_q  [NUM_FADERS];
	logic [POS_W-1:0]   held_q   [NUM_FADERS];
	logic [PER_W-1:0]   tick_q;
	logic [FADER_W-1:0] refresh_q;

	logic               go;
	logic               in_range;
	logic [FADER_W-1:0] f;
	logic [FADER_W-1:0] sel;
	logic [POS_W-1:0]   sum_rd;
	logic [CNT_W-1:0]   count_rd;
	logic [POS_W-1:0]   held_rd;
	logic [POS_W-1:0]   sum_new;
	logic               last;
	logic [POS_W-1:0]   diff;
	logic               update;
	logic [POS_W-1:0]   held_new;
	logic               tick_zero;
	logic [PER_W-1:0]   per_eff;
	logic [PER_W:0]     tick_inc;
	logic [PER_W-1:0]   tick_next;
	logic [FADER_W-1:0] refresh_next;

	assign in_stall = valid_s1 & ~q_space;
	assign go       = valid_s1 & q_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1   <= func;
			fader_s1  <= fader_index;
			sample_s1 <= sample_value;
		end
	end

	always_comb begin
		in_range = (int'(fader_s1) < NUM_FADERS);
		f        = FADER_W'(fader_s1);
		sel      = func_s1 ? refresh_q : f;
		sum_rd   = '0;
		count_rd = '0;
		held_rd  = '0;
		for (int i = 0; i < NUM_FADERS; i++) begin
			if (FADER_W'(i) == f) begin
				sum_rd   = sum_q[i];
				count_rd = count_q[i];
			end
			if (FADER_W'(i) == sel)
				held_rd = held_q[i];
		end

		sum_new = sum_rd + POS_W'(sample_s1);
		last    = (count_rd == CNT_W'(SAMPLES_PER_READING - 1));
		diff    = (sum_new >= held_rd) ? sum_new - held_rd : held_rd - sum_new;
		update  = (diff > POS_W'(threshold));

		// A large jump is taken at once; a small one only nudges the held value.
		if (diff > {threshold, 1'b0})
			held_new = sum_new;
		else if (sum_new > held_rd)
			held_new = held_rd + 1'b1;
		else
			held_new = held_rd - 1'b1;

		tick_zero    = (tick_q == '0);
		per_eff      = (period == '0) ? PER_W'(1) : period;
		tick_inc     = {1'b0, tick_q} + 1'b1;
		tick_next    = (tick_inc >= {1'b0, per_eff}) ? '0 : tick_inc[PER_W-1:0];
		refresh_next = (32'(refresh_q) == NUM_FADERS - 1) ? '0 : refresh_q + 1'b1;

		push                = go & (func_s1 ? tick_zero : (in_range & last & update));
		push_cmd.fader      = sel;
		push_cmd.pos        = func_s1 ? held_rd : sum_new;
		push_cmd.is_refresh = func_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FADERS; i++) begin
				sum_q[i]   <= '0;
				count_q[i] <= '0;
				held_q[i]  <= '0;
			end
			tick_q    <= '0;
			refresh_q <= '0;
		end else if (go) begin
			if (func_s1) begin
				if (tick_zero)
					refresh_q <= refresh_next;
				tick_q <= tick_next;
			end else if (in_range) begin
				for (int i = 0; i < NUM_FADERS; i++) begin
					if (FADER_W'(i) == f) begin
						if (last) begin
							sum_q[i]   <= '0;
							count_q[i] <= '0;
							if (update)
								held_q[i] <= held_new;
						end else begin
							sum_q[i]   <= sum_new;
							count_q[i] <= count_rd + 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

// ===== hdl/fdpb_back.sv =====
// Output stage: maps a queued message to its channel and bend value and holds it for the sink.
`timescale 1ns / 1ps

module fdpb_back
	import fdpb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  cmd_t                    q_head,
	output logic                    q_pop,
	input  chan_regs_t              chan_regs,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CH_W-1:0]         channel,
	output logic signed [POS_W-1:0] bend_value,
	output logic                    is_refresh
);

	logic                    out_valid_q;
	logic [CH_W-1:0]         channel_q;
	logic signed [POS_W-1:0] bend_q;
	logic                    refresh_q;

	assign q_pop = q_valid & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || !out_stall)
			out_valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			channel_q <= channel_of(q_head.fader, chan_regs);
			bend_q    <= $signed(q_head.pos - BEND_CENTER);
			refresh_q <= q_head.is_refresh;
		end
	end

	assign out_valid  = out_valid_q;
	assign channel    = channel_q;
	assign bend_value = bend_q;
	assign is_refresh = refresh_q;

endmodule

// ===== hdl/fader_deadband_pitch_bend.sv =====
// A transaction that yields a result passes the input register, the two-entry command queue
// and the output register, and a stall delays it further. The block takes one transaction per
// cycle while in_stall is low; the queue lets the sink stall without stopping the input until it is full.
// Reset clears all fader sums, counts and held positions, the tick counter and the refresh
// pointer, and loads the configuration registers with their defaults. No clearing pass.
`timescale 1ns / 1ps

module fader_deadband_pitch_bend
	import fdpb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic [FIDX_W-1:0]       fader_index,
	input  logic [SAMPLE_W-1:0]     sample_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CH_W-1:0]         channel,
	output logic signed [POS_W-1:0] bend_value,
	output logic                    is_refresh,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data
);

	logic [THR_W-1:0] thr_q;
	logic [PER_W-1:0] period_q;
	chan_regs_t       chan_q;

	logic q_space;
	logic push;
	cmd_t push_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			period_q <= PERIOD_RESET;
			for (int i = 0; i < NUM_CHAN_REGS; i++)
				chan_q[i] <= CH_W'(i + 1);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				CFG_PERIOD:    period_q  <= cfg_data[PER_W-1:0];
				CFG_CHAN0:     chan_q[0] <= cfg_data[CH_W-1:0];
				CFG_CHAN1:     chan_q[1] <= cfg_data[CH_W-1:0];
				CFG_CHAN2:     chan_q[2] <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	fdpb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.fader_index  (fader_index),
		.sample_value (sample_value),
		.threshold    (thr_q),
		.period       (period_q),
		.q_space      (q_space),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	fdpb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.space      (q_space),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	fdpb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.chan_regs  (chan_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel    (channel),
		.bend_value (bend_value),
		.is_refresh (is_refresh)
	);

endmodule

// ===== hdl/fdpb_checker.sv =====
// Port-level checker for the fader deadband block, bound to the top level.
`timescale 1ns / 1ps
`include "fader_deadband_pitch_bend_assert.svh"

module fdpb_checker
	import fdpb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [CH_W-1:0]         channel,
	input logic signed [POS_W-1:0] bend_value,
	input logic                    is_refresh
);

	// A stalled transaction stays offered with the same payload.
	`FDPB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(channel) && $stable(bend_value) && $stable(is_refresh), "stalled result changed")

	// A free sink over the sampled past cycles drains the queue far enough that the input is taken.
	`FDPB_ASSERT_IMPL(a_no_stall_when_drained, $past(!out_stall) && $past(!out_stall, 2), !in_stall, "input stalled with a free sink")

	// Sums of sixteen 10-bit readings never exceed 16368, so the bend stays at or below 8176.
	`FDPB_ASSERT_IMPL(a_bend_range, out_valid, bend_value <= 14'sd8176, "bend value beyond reachable range")

endmodule

bind fader_deadband_pitch_bend fdpb_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.channel    (channel),
	.bend_value (bend_value),
	.is_refresh (is_refresh)
);
